// ===== sv/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none
package sitda_pkg;

  localparam int CHAR_W      = 6;
  localparam int OUT_TDATA_W = 8;
  localparam int STEP_BITS   = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_FIND,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;        // capture a new input value
    logic shift;       // one conversion step of STEP_BITS bits
    logic find;        // locate the leading nonzero digit
    logic emit_sign;   // put the minus sign into the output register
    logic emit_digit;  // put the current digit into the output register
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic negative;
    logic out_free;
    logic idx_zero;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/sitda_ctrl.sv =====
// Controller state machine that sequences conversion and character output.
`default_nettype none
module sitda_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sitda_pkg::status_t status,
  output sitda_pkg::cmd_t        cmd
);
  import sitda_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.conv_done) state_next = ST_FIND;
      end
      ST_FIND: begin
        state_next = status.negative ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (status.out_free) state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (status.out_free && status.idx_zero) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      ST_FIND: begin
        cmd.find = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = status.out_free;
      end
      ST_DIGITS: begin
        cmd.emit_digit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sitda_dp.sv =====
// Datapath: magnitude, shift-and-add-3 BCD conversion and the output register.
`default_nettype none
module sitda_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [DATA_WIDTH-1:0]         value,
  input  wire sitda_pkg::cmd_t               cmd,
  output sitda_pkg::status_t                 status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [sitda_pkg::CHAR_W-1:0]       out_char,
  output logic                               out_last
);
  import sitda_pkg::*;

  localparam int ITER   = (DATA_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_W  = ITER * STEP_BITS;
  localparam int ND     = (DATA_WIDTH * 31) / 100 + 1;
  localparam int BCD_W  = ND * 4;
  localparam int IDX_W  = (ND > 1) ? $clog2(ND) : 1;
  localparam int ITER_W = (ITER > 1) ? $clog2(ITER) : 1;

  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_next;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_next;
  logic              negative;
  logic [ITER_W-1:0] iter_cnt;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  lead;
  logic [DATA_WIDTH-1:0] abs_val;

  assign abs_val = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;

  // Each step adds three to any digit of five or more, then shifts one bit in.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd;
    m = mag;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  // Highest digit position that is nonzero; zero when the value is zero.
  always_comb begin
    lead = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) lead = IDX_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= MAG_W'(abs_val);
      bcd      <= '0;
      negative <= value[DATA_WIDTH-1];
      iter_cnt <= '0;
    end else if (cmd.shift) begin
      mag      <= mag_next;
      bcd      <= bcd_next;
      iter_cnt <= iter_cnt + 1'b1;
    end
    if (cmd.find) begin
      idx <= lead;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= CHAR_ZERO + CHAR_W'(bcd[idx*4 +: 4]);
      out_last <= (idx == '0);
    end
  end

  assign status.conv_done = (iter_cnt == ITER_W'(ITER - 1));
  assign status.negative  = negative;
  assign status.out_free  = !out_valid || out_ready;
  assign status.idx_zero  = (idx == '0);

endmodule
`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Sequence: accept a value, convert it in the BCD shift loop, find the leading digit,
// then one character per cycle while the output is taken.
// One value at a time: a new value is accepted only once the controller is idle;
// the 4-bit-per-cycle BCD shift loop sets the conversion time.
// Reset (synchronous, active high) returns the controller to idle and empties the output.
`default_nettype none
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // value
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sitda_pkg::OUT_TDATA_W-1:0]        m_tdata,  // character, zero pad
  output logic                                     m_tlast
);
  import sitda_pkg::*;

  cmd_t                cmd;
  status_t             status;
  logic [CHAR_W-1:0]   out_char;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sitda_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata[DATA_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char};

endmodule
`default_nettype wire

// ===== bench/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int DATA_WIDTH  = 32;
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 95;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // value
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // character, zero pad
  logic                   m_tlast;

  text_char_t pending_text[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  signed_int_to_decimal_ascii #(.DATA_WIDTH(DATA_WIDTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Expected text of one value, one entry per character, pushed in emission order.
  function automatic void convert_to_text(input logic [DATA_WIDTH-1:0] value);
    logic [DATA_WIDTH-1:0] magnitude;
    logic [3:0]            digits[$];
    text_char_t            ch;
    magnitude = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (value[DATA_WIDTH-1]) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      pending_text.push_back(ch);
    end
    for (int i = 0; i < digits.size(); i++) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
      ch.last = (i == digits.size() - 1);
      pending_text.push_back(ch);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_text.size() == 0) begin
        note_mismatch($sformatf("unexpected beat tdata=%0d tlast=%0b", m_tdata, m_tlast));
      end else begin
        want = pending_text.pop_front();
        if (m_tdata !== {{(OUT_TDATA_W-CHAR_W){1'b0}}, want.code} || m_tlast !== want.last)
          note_mismatch($sformatf("expected tdata=%0d tlast=%0b, got tdata=%0d tlast=%0b",
                                  want.code, want.last, m_tdata, m_tlast));
      end
    end
  end

  // Offers one value, with random idle cycles ahead of it; tvalid stays high
  // after the beat unless the next call or a drain lowers it.
  task automatic send_value(input logic [DATA_WIDTH-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(value);
    do @(posedge clk); while (!s_tready);
    convert_to_text(value);
  endtask

  task automatic drain_text;
    s_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // Mix of full-range words, values of a chosen digit count, powers of ten
  // and their neighbors, small numbers, and values next to both extremes.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    int unsigned           kind;
    int unsigned           ndig;
    logic [DATA_WIDTH-1:0] lo;
    logic [DATA_WIDTH-1:0] hi;
    logic [DATA_WIDTH-1:0] mag;
    kind = $urandom_range(9);
    lo = 1;
    if (kind <= 3) return $urandom;
    if (kind == 9) begin
      if ($urandom_range(1)) return 32'h8000_0000 + $urandom_range(20);
      return 32'h7FFF_FFFF - $urandom_range(20);
    end
    if (kind == 8) begin
      mag = $urandom_range(20);
    end else begin
      ndig = $urandom_range(1, 10);
      for (int i = 1; i < ndig; i++) lo = lo * 10;
      if (kind == 7) begin
        mag = lo - $urandom_range(1);
      end else begin
        hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        mag = $urandom_range(hi, (ndig == 1) ? 0 : lo);
      end
    end
    return $urandom_range(1) ? (~mag + 1'b1) : mag;
  endfunction

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_value(pick_value());
    drain_text();
  endtask

  task automatic test_directed;
    logic [DATA_WIDTH-1:0] values[$];
    values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
               32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
               32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967286, -32'sd1000000000};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (values[i]) send_value(values[i]);
    drain_text();
  endtask

  task automatic test_no_idle;
    run_random(ITEMS_PER_PHASE, 0, 0);
  endtask

  task automatic test_sender_idle;
    // Halfway through, the sender holds off until the whole backlog is out.
    run_random(ITEMS_PER_PHASE / 2, 53, 0);
    run_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2, 53, 0);
  endtask

  task automatic test_receiver_stall;
    run_random(ITEMS_PER_PHASE, 0, 53);
  endtask

  task automatic test_both_idle;
    run_random(ITEMS_PER_PHASE, 16, 16);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    recv_stall_pct = 0;
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
sv/sitda_pkg.sv
sv/sitda_ctrl.sv
sv/sitda_dp.sv
sv/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
